FILE: design/bpcu_pkg.sv
// ----------------------------------------------------------------------------
// BMP pixel channel unpacker package
// Shared widths, channel codes, register indexes and the configuration type.
// ----------------------------------------------------------------------------
`default_nettype none

package bpcu_pkg;

    // Default largest image dimension; sets the counter widths.
    localparam int MAX_DIM_DEFAULT = 16384;

    localparam int BYTE_W     = 8;
    localparam int LANES      = 4;
    localparam int WORD_W     = BYTE_W * LANES;
    localparam int INDEX_W    = 28;
    localparam int CODE_W     = 3;
    localparam int MAP_W      = CODE_W * LANES;
    localparam int BPP_W      = 3;
    localparam int DIM_REG_W  = 15;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;
    localparam int PAD_W      = 2;

    // Pixel sizes in bytes.
    localparam logic [BPP_W-1:0] BPP_RGB  = 3'd3;
    localparam logic [BPP_W-1:0] BPP_RGBA = 3'd4;

    // Channel codes used by both channel maps.
    localparam logic [CODE_W-1:0] CH_RED   = 3'd0;
    localparam logic [CODE_W-1:0] CH_GREEN = 3'd1;
    localparam logic [CODE_W-1:0] CH_BLUE  = 3'd2;
    localparam logic [CODE_W-1:0] CH_ALPHA = 3'd3;
    localparam logic [CODE_W-1:0] CH_NONE  = 3'd4;

    // Fill value for an alpha lane when the pixel carried no alpha byte.
    localparam logic [BYTE_W-1:0] ALPHA_FILL = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BYTES_PER_PIXEL = 3'd0,
        REG_IMAGE_WIDTH     = 3'd1,
        REG_IMAGE_HEIGHT    = 3'd2,
        REG_SRC_CHANNEL_MAP = 3'd3,
        REG_DST_CHANNEL_MAP = 3'd4,
        REG_FLIP_ROWS       = 3'd5
    } reg_idx_t;

    // Configuration register set.
    typedef struct packed {
        logic [BPP_W-1:0]     bytes_per_pixel;
        logic [DIM_REG_W-1:0] image_width;
        logic [DIM_REG_W-1:0] image_height;
        logic [MAP_W-1:0]     src_channel_map;
        logic [MAP_W-1:0]     dst_channel_map;
        logic                 flip_rows;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        bytes_per_pixel: BPP_RGB,
        image_width:     15'd1,
        image_height:    15'd1,
        src_channel_map: 12'd2058,
        dst_channel_map: 12'd1672,
        flip_rows:       1'b0
    };

    // Finished pixel data passed from the gather stage to the output stage.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } pix_data_t;

endpackage

`default_nettype wire

FILE: design/bpcu_cfg_regs.sv
// ----------------------------------------------------------------------------
// BPCU configuration registers
// Holds the six configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcu_cfg_regs import bpcu_pkg::*; (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_wr_en,
    input  wire  [CFG_ADDR_W-1:0] cfg_addr,
    input  wire  [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; indexes beyond the register list are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BYTES_PER_PIXEL: cfg_next.bytes_per_pixel = cfg_wr_data[BPP_W-1:0];
                REG_IMAGE_WIDTH:     cfg_next.image_width     = cfg_wr_data[DIM_REG_W-1:0];
                REG_IMAGE_HEIGHT:    cfg_next.image_height    = cfg_wr_data[DIM_REG_W-1:0];
                REG_SRC_CHANNEL_MAP: cfg_next.src_channel_map = cfg_wr_data[MAP_W-1:0];
                REG_DST_CHANNEL_MAP: cfg_next.dst_channel_map = cfg_wr_data[MAP_W-1:0];
                REG_FLIP_ROWS:       cfg_next.flip_rows       = cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: design/bpcu_pixel_gather.sv
// ----------------------------------------------------------------------------
// BPCU pixel gather stage
// Steers each byte into its lanes, counts slots, columns and rows, swallows
// row padding and registers one finished pixel with its clamped position.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcu_pixel_gather import bpcu_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  cfg_t                         cfg,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [BYTE_W-1:0]            s_pixel_byte,
    output logic                         pix_valid,
    input  wire                          pix_take,
    output pix_data_t                    pix_data,
    output logic [$clog2(MAX_DIM)-1:0]   pix_row,
    output logic [$clog2(MAX_DIM)-1:0]   pix_col,
    output logic [$clog2(MAX_DIM+1)-1:0] pix_width
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (DW > DIM_REG_W) ? DW : DIM_REG_W;

    // Gather state.
    logic [1:0]        slot_reg,  slot_next;
    logic [WORD_W-1:0] acc_reg,   acc_next;
    logic              alpha_reg, alpha_next;
    logic [CW-1:0]     col_reg,   col_next;
    logic [CW-1:0]     row_reg,   row_next;
    logic [PAD_W-1:0]  pad_reg,   pad_next;

    // Finished pixel register.
    logic              pix_valid_reg, pix_valid_next;
    pix_data_t         pix_data_reg;
    logic [CW-1:0]     pix_row_reg;
    logic [CW-1:0]     pix_col_reg;
    logic [DW-1:0]     pix_width_reg;

    logic              byte_fire;
    logic              pix_load;
    logic [BPP_W-1:0]  bpp;
    logic [CODE_W-1:0] slot_code;
    logic [CODE_W-1:0] lane_code [LANES];
    logic [WORD_W-1:0] acc_merged;
    logic              alpha_merged;
    logic [WORD_W-1:0] word_out;
    logic              pixel_done;
    logic [DW-1:0]     width;
    logic [DW-1:0]     height;
    logic [DW-1:0]     col_plus;
    logic [DW-1:0]     row_plus;
    logic              row_end;
    logic              image_end;
    logic [CW-1:0]     col_pos;
    logic [CW-1:0]     row_pos;
    logic [CW-1:0]     row_dest;

    // Zero acts as one, anything above the maximum acts as the maximum.
    function automatic logic [DW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(v);
        if (wide == '0) begin
            clamp_dim = DW'(1);
        end else if (wide > CMP_W'(MAX_DIM)) begin
            clamp_dim = DW'(MAX_DIM);
        end else begin
            clamp_dim = DW'(wide);
        end
    endfunction

    // The stage takes a byte whenever its pixel register is free or draining.
    assign s_ready   = !pix_valid_reg || pix_take;
    assign byte_fire = s_valid && s_ready;

    // Pixel size; any value other than four bytes acts as three.
    assign bpp = (cfg.bytes_per_pixel == BPP_RGBA) ? BPP_RGBA : BPP_RGB;

    // Lane steering of the incoming byte and alpha fill of the finished word.
    always_comb begin
        slot_code    = cfg.src_channel_map[CODE_W*slot_reg +: CODE_W];
        acc_merged   = acc_reg;
        alpha_merged = alpha_reg || (slot_code == CH_ALPHA);
        for (int i = 0; i < LANES; i++) begin
            lane_code[i] = cfg.dst_channel_map[CODE_W*i +: CODE_W];
            if ((slot_code <= CH_ALPHA) && (lane_code[i] == slot_code)) begin
                acc_merged[BYTE_W*i +: BYTE_W] = acc_reg[BYTE_W*i +: BYTE_W] | s_pixel_byte;
            end
        end
        word_out = acc_merged;
        for (int i = 0; i < LANES; i++) begin
            if (!alpha_merged && (lane_code[i] == CH_ALPHA)) begin
                word_out[BYTE_W*i +: BYTE_W] = ALPHA_FILL;
            end
        end
        pixel_done = ((BPP_W'(slot_reg) + BPP_W'(1)) >= bpp);
    end

    // Position of the pixel, clamped to the current image and mirrored if asked.
    always_comb begin
        width     = clamp_dim(cfg.image_width);
        height    = clamp_dim(cfg.image_height);
        col_plus  = DW'(col_reg) + DW'(1);
        row_plus  = DW'(row_reg) + DW'(1);
        row_end   = (col_plus >= width);
        image_end = (row_plus >= height);
        col_pos   = (DW'(col_reg) >= width)  ? CW'(width - DW'(1))  : col_reg;
        row_pos   = (DW'(row_reg) >= height) ? CW'(height - DW'(1)) : row_reg;
        row_dest  = cfg.flip_rows ? CW'(height - DW'(1) - DW'(row_pos)) : row_pos;
    end

    // Next state of the counters and the accumulator.
    always_comb begin
        slot_next  = slot_reg;
        acc_next   = acc_reg;
        alpha_next = alpha_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pad_next   = pad_reg;
        pix_load   = 1'b0;
        if (byte_fire) begin
            if (pad_reg != '0) begin
                // Padding byte at the end of a row: drop it.
                pad_next = pad_reg - PAD_W'(1);
            end else if (!pixel_done) begin
                slot_next  = slot_reg + 2'd1;
                acc_next   = acc_merged;
                alpha_next = alpha_merged;
            end else begin
                pix_load   = 1'b1;
                slot_next  = '0;
                acc_next   = '0;
                alpha_next = 1'b0;
                if (row_end) begin
                    col_next = '0;
                    pad_next = (bpp == BPP_RGB) ? width[PAD_W-1:0] : '0;
                    row_next = image_end ? '0 : CW'(row_plus);
                end else begin
                    col_next = CW'(col_plus);
                end
            end
        end
        pix_valid_next = pix_load || (pix_valid_reg && !pix_take);
    end

    // Control and gather state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg      <= '0;
            acc_reg       <= '0;
            alpha_reg     <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            pad_reg       <= '0;
            pix_valid_reg <= 1'b0;
        end else begin
            slot_reg      <= slot_next;
            acc_reg       <= acc_next;
            alpha_reg     <= alpha_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pad_reg       <= pad_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // Pixel payload, loaded when a pixel completes.
    always_ff @(posedge aclk) begin
        if (pix_load) begin
            pix_data_reg.word <= word_out;
            pix_data_reg.last <= row_end && image_end;
            pix_row_reg       <= row_dest;
            pix_col_reg       <= col_pos;
            pix_width_reg     <= width;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix_data  = pix_data_reg;
    assign pix_row   = pix_row_reg;
    assign pix_col   = pix_col_reg;
    assign pix_width = pix_width_reg;

endmodule

`default_nettype wire

FILE: design/bpcu_index_calc.sv
// ----------------------------------------------------------------------------
// BPCU index and output stage
// Forms row times width plus column and holds the result word for the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcu_index_calc import bpcu_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          pix_valid,
    output logic                         pix_take,
    input  pix_data_t                    pix_data,
    input  wire  [$clog2(MAX_DIM)-1:0]   pix_row,
    input  wire  [$clog2(MAX_DIM)-1:0]   pix_col,
    input  wire  [$clog2(MAX_DIM+1)-1:0] pix_width,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [WORD_W-1:0]            m_pixel_word,
    output logic [INDEX_W-1:0]           m_pixel_index,
    output logic                         m_last_pixel
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int PW = CW + DW;
    localparam int SW = (PW + 1 > INDEX_W) ? PW + 1 : INDEX_W;

    logic               m_valid_reg;
    logic [WORD_W-1:0]  word_reg;
    logic [INDEX_W-1:0] index_reg;
    logic               last_reg;
    logic [PW-1:0]      product;
    logic [SW-1:0]      index_sum;

    // The output register frees when empty or when the sink takes its word.
    assign pix_take = !m_valid_reg || m_ready;

    // Destination index, kept to its low bits.
    assign product   = PW'(pix_row) * PW'(pix_width);
    assign index_sum = SW'(product) + SW'(pix_col);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pix_take) begin
            m_valid_reg <= pix_valid;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (pix_take && pix_valid) begin
            word_reg  <= pix_data.word;
            index_reg <= index_sum[INDEX_W-1:0];
            last_reg  <= pix_data.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_word  = word_reg;
    assign m_pixel_index = index_reg;
    assign m_last_pixel  = last_reg;

endmodule

`default_nettype wire

FILE: design/bmp_pixel_channel_unpacker.sv
// Latency: a pixel's word is registered in the gather stage's pixel register, then in the output register.
// Throughput: one byte per cycle while the output is not stalled, set by the gather stage; one word every three or four
// data bytes, and row padding bytes give no word.
// Reset (aresetn low, synchronous) clears the slot, column, row and padding counters,
// empties both stages and loads every configuration register with its default.
// ----------------------------------------------------------------------------
// BMP pixel channel unpacker
// Gathers bitmap pixel bytes into packed 32-bit channel-swizzled words with
// their destination index and an end-of-image mark.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_pixel_channel_unpacker import bpcu_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_wr_en,
    input  wire  [CFG_ADDR_W-1:0] cfg_addr,
    input  wire  [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  [BYTE_W-1:0]     s_pixel_byte,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [WORD_W-1:0]     m_pixel_word,
    output logic [INDEX_W-1:0]    m_pixel_index,
    output logic                  m_last_pixel
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);

    cfg_t          cfg;
    logic          pix_valid;
    logic          pix_take;
    pix_data_t     pix_data;
    logic [CW-1:0] pix_row;
    logic [CW-1:0] pix_col;
    logic [DW-1:0] pix_width;

    // Configuration registers.
    bpcu_cfg_regs u_cfg_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Byte gather, lane steering and position counters.
    bpcu_pixel_gather #(
        .MAX_DIM (MAX_DIM)
    ) u_gather (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_byte (s_pixel_byte),
        .pix_valid    (pix_valid),
        .pix_take     (pix_take),
        .pix_data     (pix_data),
        .pix_row      (pix_row),
        .pix_col      (pix_col),
        .pix_width    (pix_width)
    );

    // Index multiply-add and output register.
    bpcu_index_calc #(
        .MAX_DIM (MAX_DIM)
    ) u_index (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pix_valid     (pix_valid),
        .pix_take      (pix_take),
        .pix_data      (pix_data),
        .pix_row       (pix_row),
        .pix_col       (pix_col),
        .pix_width     (pix_width),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_word  (m_pixel_word),
        .m_pixel_index (m_pixel_index),
        .m_last_pixel  (m_last_pixel)
    );

endmodule

`default_nettype wire

FILE: design/bpcu_checker.sv
// ----------------------------------------------------------------------------
// BPCU port checker
// Watches the unpacker's ports for handshake and pipeline timing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcu_checker import bpcu_pkg::*; (
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  s_valid,
    input wire                  s_ready,
    input wire                  m_valid,
    input wire                  m_ready,
    input wire [WORD_W-1:0]     m_pixel_word,
    input wire [INDEX_W-1:0]    m_pixel_index,
    input wire                  m_last_pixel
);

    // A stalled word keeps its valid and its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pixel_word)
            && $stable(m_pixel_index) && $stable(m_last_pixel)))
        else $error("result word changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The input only backs up when a word is waiting at the output.
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with an empty output");

    // A fresh word comes from an accepted source byte, through the pixel register and then the output register.
    a_word_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result word without a source byte");

endmodule

bind bmp_pixel_channel_unpacker bpcu_checker u_bpcu_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pixel_word  (m_pixel_word),
    .m_pixel_index (m_pixel_index),
    .m_last_pixel  (m_last_pixel)
);

`default_nettype wire

FILE: bench/tb_bmp_pixel_channel_unpacker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BMP pixel channel unpacker testbench
// Streams pixel-area bytes through the unpacker under a series of image
// setups and sender/receiver stall patterns. Every output word is checked
// (packed pixel, destination index and last mark) against a scoreboard that
// predicts the gather, swizzle, padding and row logic one input byte at a time.
// ----------------------------------------------------------------------------

import bpcu_pkg::*;

// One predicted output word.
typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [INDEX_W-1:0] index;
    logic               last;
} pixel_out_t;

class pixel_word_scoreboard;
    cfg_t        cfg;
    logic [1:0]  slot;
    logic [31:0] accum;
    bit          alpha_seen;
    int unsigned col_count;
    int unsigned row_count;
    int unsigned pad_left;
    pixel_out_t  pending_pixels[$];
    int unsigned mismatches;

    function new();
        cfg        = CFG_RESET;
        slot       = '0;
        accum      = '0;
        alpha_seen = 1'b0;
        col_count  = 0;
        row_count  = 0;
        pad_left   = 0;
        mismatches = 0;
    endfunction

    // Zero counts as one, anything above the largest dimension is clipped.
    function int unsigned clamp_dim(logic [DIM_REG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
        return v;
    endfunction

    // Every pixel size other than four bytes behaves as three.
    function int unsigned pixel_size();
        return (cfg.bytes_per_pixel == BPP_RGBA) ? 4 : 3;
    endfunction

    // Bytes in one whole image under the current setup, padding included.
    function int unsigned area_bytes();
        int unsigned w;
        int unsigned pad;
        w   = clamp_dim(cfg.image_width);
        pad = (pixel_size() == 3) ? (w & 3) : 0;
        return clamp_dim(cfg.image_height) * (w * pixel_size() + pad);
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_BYTES_PER_PIXEL: cfg.bytes_per_pixel = value[BPP_W-1:0];
            REG_IMAGE_WIDTH:     cfg.image_width     = value[DIM_REG_W-1:0];
            REG_IMAGE_HEIGHT:    cfg.image_height    = value[DIM_REG_W-1:0];
            REG_SRC_CHANNEL_MAP: cfg.src_channel_map = value[MAP_W-1:0];
            REG_DST_CHANNEL_MAP: cfg.dst_channel_map = value[MAP_W-1:0];
            REG_FLIP_ROWS:       cfg.flip_rows       = value[0];
            default: ;
        endcase
    endfunction

    // Note one accepted input byte and queue the pixel it completes, if any.
    function void take_byte(logic [BYTE_W-1:0] b);
        int unsigned     size;
        int unsigned     w;
        int unsigned     h;
        int unsigned     col_pos;
        int unsigned     row_pos;
        logic [2:0]      code;
        longint unsigned pos;
        pixel_out_t      res;

        // Row padding is swallowed without touching the pixel.
        if (pad_left > 0) begin
            pad_left--;
            return;
        end

        // Copy the byte into every lane that asks for its channel.
        size = pixel_size();
        code = cfg.src_channel_map[3*slot +: 3];
        if (code == CH_ALPHA) alpha_seen = 1'b1;
        if (code <= CH_ALPHA) begin
            for (int lane = 0; lane < LANES; lane++) begin
                if (cfg.dst_channel_map[3*lane +: 3] == code)
                    accum[8*lane +: 8] = accum[8*lane +: 8] | b;
            end
        end

        if (slot + 1 < size) begin
            slot++;
            return;
        end

        // Alpha lanes are opaque when the pixel carried no alpha byte.
        res.word = accum;
        if (!alpha_seen) begin
            for (int lane = 0; lane < LANES; lane++) begin
                if (cfg.dst_channel_map[3*lane +: 3] == CH_ALPHA)
                    res.word[8*lane +: 8] = ALPHA_FILL;
            end
        end

        // Counters past the current bounds count as the final position.
        w       = clamp_dim(cfg.image_width);
        h       = clamp_dim(cfg.image_height);
        col_pos = (col_count >= w) ? w - 1 : col_count;
        row_pos = (row_count >= h) ? h - 1 : row_count;
        if (cfg.flip_rows) row_pos = h - 1 - row_pos;
        pos       = row_pos;
        pos       = pos * w + col_pos;
        res.index = pos[INDEX_W-1:0];
        res.last  = (col_count + 1 >= w) && (row_count + 1 >= h);

        // Advance the column, and at the end of a row load its padding.
        if (col_count + 1 >= w) begin
            col_count = 0;
            pad_left  = (size == 3) ? (w & 3) : 0;
            row_count = (row_count + 1 >= h) ? 0 : row_count + 1;
        end else begin
            col_count++;
        end

        slot       = '0;
        accum      = '0;
        alpha_seen = 1'b0;
        pending_pixels.push_back(res);
    endfunction

    // Compare one accepted output word with the oldest prediction.
    function void check_word(logic [WORD_W-1:0] word, logic [INDEX_W-1:0] index,
                             logic last);
        pixel_out_t want;
        if (pending_pixels.size() == 0) begin
            $error("unexpected output word %h at index %0d", word, index);
            mismatches++;
            return;
        end
        want = pending_pixels.pop_front();
        if (word !== want.word) begin
            $error("pixel_word: expected %h, got %h", want.word, word);
            mismatches++;
        end
        if (index !== want.index) begin
            $error("pixel_index: expected %0d, got %0d", want.index, index);
            mismatches++;
        end
        if (last !== want.last) begin
            $error("last_pixel: expected %b, got %b", want.last, last);
            mismatches++;
        end
    endfunction
endclass

module tb_bmp_pixel_channel_unpacker;

    localparam int SETTLE_CYCLES  = 6;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int ITEMS_PER_MODE = 600;

    // Channel codes outside the defined set.
    localparam logic [CODE_W-1:0] CH_SPARE_5 = 3'd5;
    localparam logic [CODE_W-1:0] CH_SPARE_6 = 3'd6;
    localparam logic [CODE_W-1:0] CH_SPARE_7 = 3'd7;

    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr     = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_pixel_byte = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [WORD_W-1:0]     m_pixel_word;
    logic [INDEX_W-1:0]    m_pixel_index;
    logic                  m_last_pixel;

    int unsigned send_idle_pct = 16;
    int unsigned recv_idle_pct = 81;
    int unsigned cycle_count   = 0;

    pixel_word_scoreboard expected_pixels;

    bmp_pixel_channel_unpacker uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_byte  (s_pixel_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_word  (m_pixel_word),
        .m_pixel_index (m_pixel_index),
        .m_last_pixel  (m_last_pixel)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The receiver stalls at random with the current percentage.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check output words first so that a word accepted on the same edge
    // can never be matched against a prediction queued at that edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                expected_pixels.check_word(m_pixel_word, m_pixel_index, m_last_pixel);
            if (s_valid && s_ready)
                expected_pixels.take_byte(s_pixel_byte);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("bmp_pixel_channel_unpacker test failed");
            $finish;
        end
    end

    // Register writes are mirrored into the scoreboard.
    task automatic write_cfg_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        expected_pixels.set_reg(idx, value);
    endtask

    task automatic load_image_setup(input logic [BPP_W-1:0] bpp,
                                    input logic [DIM_REG_W-1:0] w,
                                    input logic [DIM_REG_W-1:0] h,
                                    input logic [MAP_W-1:0] src_map,
                                    input logic [MAP_W-1:0] dst_map,
                                    input logic flip);
        write_cfg_reg(REG_BYTES_PER_PIXEL, CFG_DATA_W'(bpp));
        write_cfg_reg(REG_IMAGE_WIDTH, w);
        write_cfg_reg(REG_IMAGE_HEIGHT, h);
        write_cfg_reg(REG_SRC_CHANNEL_MAP, CFG_DATA_W'(src_map));
        write_cfg_reg(REG_DST_CHANNEL_MAP, CFG_DATA_W'(dst_map));
        write_cfg_reg(REG_FLIP_ROWS, CFG_DATA_W'(flip));
    endtask

    // Offer one input byte after a random idle gap and hold it until taken.
    // Valid only drops when a gap follows, so it gets one update per step.
    task automatic send_area_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_pixel_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off the sender until every predicted word has come out, then
    // give the pipeline time to settle.
    task automatic wait_pixels_out();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_pixels.pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly codes from the defined set, sometimes any 12-bit pattern.
    function automatic logic [MAP_W-1:0] random_map();
        logic [MAP_W-1:0] m;
        if ($urandom_range(0, 2) == 0) return MAP_W'($urandom);
        for (int s = 0; s < LANES; s++)
            m[CODE_W*s +: CODE_W] = CODE_W'($urandom_range(CH_RED, CH_NONE));
        return m;
    endfunction

    // Small dimensions for most setups, with zero and oversized values mixed in.
    function automatic logic [DIM_REG_W-1:0] random_dim(input int unsigned small_max);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) begin
            case ($urandom_range(0, 2))
                0: return DIM_REG_W'(MAX_DIM_DEFAULT);
                1: return '1;
                default: return DIM_REG_W'($urandom_range(MAX_DIM_DEFAULT + 1, 32767));
            endcase
        end
        return DIM_REG_W'($urandom_range(1, small_max));
    endfunction

    task automatic pick_random_setup();
        int unsigned      r;
        logic [BPP_W-1:0] bpp;
        r = $urandom_range(0, 9);
        if (r < 4)      bpp = BPP_RGB;
        else if (r < 8) bpp = BPP_RGBA;
        else            bpp = BPP_W'($urandom);
        load_image_setup(bpp, random_dim(8), random_dim(4), random_map(), random_map(),
                         1'($urandom_range(0, 1)));
    endtask

    initial begin : stimulus
        int unsigned n;
        int unsigned sent;

        expected_pixels = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset setup: a 1x1 RGB image, so each row carries one pad byte.
        send_area_byte(8'h00);
        send_area_byte(8'hFF);
        send_area_byte(8'h80);
        send_area_byte(8'h7F);
        wait_pixels_out();

        // Odd pixel size, zero dimensions and unused channel codes on both
        // maps; the alpha lane is filled since no byte carries alpha.
        load_image_setup(CH_SPARE_7, '0, '0,
                         {CH_SPARE_7, CH_RED, CH_SPARE_6, CH_SPARE_5},
                         {CH_SPARE_5, CH_RED, CH_SPARE_7, CH_ALPHA}, 1'b0);
        send_area_byte(8'hFF);
        send_area_byte(8'hFF);
        send_area_byte(8'h01);
        send_area_byte(8'h00);
        wait_pixels_out();

        // RGBA source with a duplicated lane, a zero lane and flipped rows.
        load_image_setup(BPP_RGBA, 15'd2, 15'd2,
                         {CH_RED, CH_GREEN, CH_BLUE, CH_ALPHA},
                         {CH_NONE, CH_ALPHA, CH_RED, CH_RED}, 1'b1);
        send_area_byte(8'h00);
        send_area_byte(8'hFF);
        send_area_byte(8'hAA);
        send_area_byte(8'h55);
        wait_pixels_out();

        // Shrink the width mid-row: the column is now past the new bound.
        write_cfg_reg(REG_IMAGE_WIDTH, 15'd1);
        write_cfg_reg(REG_FLIP_ROWS, CFG_DATA_W'(1'b0));
        send_area_byte(8'h12);
        send_area_byte(8'h34);
        send_area_byte(8'h56);
        send_area_byte(8'h78);
        wait_pixels_out();

        // Oversized dimensions are clipped; flipping gives very high indexes.
        load_image_setup(BPP_RGB, '1, 15'd20000,
                         {CH_NONE, CH_RED, CH_GREEN, CH_BLUE},
                         {CH_ALPHA, CH_BLUE, CH_GREEN, CH_RED}, 1'b1);
        repeat (6) send_area_byte(8'($urandom));
        wait_pixels_out();

        // Random setups under three stall patterns. Most phases stream whole
        // images; some stop partway so the next setup starts mid-image.
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 81 : 0;
            recv_idle_pct = (mode == 0) ? 81 : (mode == 1) ? 16 : 0;
            sent = 0;
            while (sent < ITEMS_PER_MODE) begin
                pick_random_setup();
                n = expected_pixels.area_bytes();
                if (n <= 150) n = n * $urandom_range(1, 2);
                else          n = $urandom_range(30, 90);
                if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 5);
                repeat (n) send_area_byte(8'($urandom));
                sent += n;
                wait_pixels_out();
            end
        end

        if (expected_pixels.pending_pixels.size() != 0) begin
            $error("%0d predicted output words never arrived",
                   expected_pixels.pending_pixels.size());
            expected_pixels.mismatches++;
        end

        if (expected_pixels.mismatches == 0) begin
            $display("bmp_pixel_channel_unpacker test passed");
        end else begin
            $display("bmp_pixel_channel_unpacker test failed");
        end
        $finish;
    end

endmodule
